>>> src/ssp_pkg.sv
`default_nettype none

package ssp_pkg;

  // symbol codes for closed runs
  typedef enum logic [1:0] {
    SYM_NONE  = 2'd0,
    SYM_BLACK = 2'd1,
    SYM_GRAY  = 2'd2,
    SYM_WHITE = 2'd3
  } sym_t;

  // configuration register indexes
  localparam logic [1:0] CFG_BLACK_LEVEL   = 2'd0;
  localparam logic [1:0] CFG_GRAY_LEVEL    = 2'd1;
  localparam logic [1:0] CFG_WHITE_LEVEL   = 2'd2;
  localparam logic [1:0] CFG_REQUIRED_RUNS = 2'd3;

  // reset values of the configuration registers
  localparam logic [7:0] BLACK_LEVEL_RST   = 8'd0;
  localparam logic [7:0] GRAY_LEVEL_RST    = 8'd128;
  localparam logic [7:0] WHITE_LEVEL_RST   = 8'd255;
  localparam logic [4:0] REQUIRED_RUNS_RST = 5'd11;

  localparam int MAX_RUNS_DEF  = 16;
  localparam int QUEUE_DEPTH   = 4;
  localparam int RESULT_DEPTH  = 2;

  // classified work for the back part: up to two closed runs per item
  typedef struct packed {
    sym_t sym_a;      // run closed by a change of value
    sym_t sym_b;      // run closed by the end of the row
    logic row_end;
    logic image_end;
  } item_t;

  typedef struct packed {
    logic row_match;
    logic image_match;
    logic last_row;
  } result_t;

endpackage

`default_nettype wire

>>> src/ssp_fifo.sv
`default_nettype none

module ssp_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> src/ssp_front.sv
`default_nettype none

module ssp_front
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] pixel,
  input  logic       row_end,
  input  logic       image_end,
  input  logic [7:0] black_level,
  input  logic [7:0] gray_level,
  input  logic [7:0] white_level,
  output item_t      item,
  output logic       item_valid
);

  logic [7:0] previous_pixel;
  logic       previous_valid;

  // black wins over gray, gray over white
  function automatic sym_t classify(input logic [7:0] value, input logic [7:0] blk,
                                    input logic [7:0] gry, input logic [7:0] wht);
    sym_t s;
    if (value == blk) begin
      s = SYM_BLACK;
    end else if (value == gry) begin
      s = SYM_GRAY;
    end else if (value == wht) begin
      s = SYM_WHITE;
    end else begin
      s = SYM_NONE;
    end
    return s;
  endfunction

  always_comb begin
    item.sym_a     = SYM_NONE;
    item.sym_b     = SYM_NONE;
    item.row_end   = row_end;
    item.image_end = row_end && image_end;
    if (previous_valid && (pixel != previous_pixel)) begin
      item.sym_a = classify(previous_pixel, black_level, gray_level, white_level);
    end
    if (row_end) begin
      item.sym_b = classify(pixel, black_level, gray_level, white_level);
    end
  end

  // items that close no symbol and end no row leave no work behind
  assign item_valid = accept && ((item.sym_a != SYM_NONE) || row_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pixel <= '0;
      previous_valid <= 1'b0;
    end else if (accept) begin
      previous_pixel <= pixel;
      previous_valid <= !row_end;
    end
  end

endmodule

`default_nettype wire

>>> src/ssp_back.sv
`default_nettype none

module ssp_back
  import ssp_pkg::*;
#(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [4:0] required_runs,
  input  logic       item_valid,
  input  item_t      item,
  output logic       item_pop,
  input  logic       result_full,
  output logic       result_push,
  output result_t    result
);

  localparam int LW = ($clog2(MAX_RUNS + 1) > 5) ? $clog2(MAX_RUNS + 1) : 5;

  sym_t                hist [MAX_RUNS];
  sym_t                h1   [MAX_RUNS];
  sym_t                h2   [MAX_RUNS];
  sym_t                want [MAX_RUNS];
  logic [MAX_RUNS-1:0] in_win;
  logic [MAX_RUNS-1:0] ok1;
  logic [MAX_RUNS-1:0] ok2;
  logic [LW-1:0]       len;
  logic                row_found;
  logic                image_found;
  logic                found1;
  logic                found2;

  // pattern length clamped to one .. MAX_RUNS
  always_comb begin
    if (required_runs == '0) begin
      len = LW'(1);
    end else if (LW'(required_runs) > LW'(MAX_RUNS)) begin
      len = LW'(MAX_RUNS);
    end else begin
      len = LW'(required_runs);
    end
  end

  // window mask and wanted symbol, oldest in window is black
  always_comb begin
    for (int i = 0; i < MAX_RUNS; i++) begin
      in_win[i] = (LW'(i) < len);
      want[i]   = (len[0] == ((i % 2) == 1)) ? SYM_WHITE : SYM_BLACK;
    end
  end

  // up to two shifts per item, window check after each
  always_comb begin
    h1 = hist;
    if (item.sym_a != SYM_NONE) begin
      for (int i = MAX_RUNS - 1; i > 0; i--) begin
        h1[i] = hist[i-1];
      end
      h1[0] = item.sym_a;
    end
    h2 = h1;
    if (item.sym_b != SYM_NONE) begin
      for (int i = MAX_RUNS - 1; i > 0; i--) begin
        h2[i] = h1[i-1];
      end
      h2[0] = item.sym_b;
    end
    for (int i = 0; i < MAX_RUNS; i++) begin
      ok1[i] = !in_win[i] || (h1[i] == want[i]);
      ok2[i] = !in_win[i] || (h2[i] == want[i]);
    end
    found1 = row_found || ((item.sym_a != SYM_NONE) && (&ok1));
    found2 = found1 || ((item.sym_b != SYM_NONE) && (&ok2));
  end

  assign item_pop           = item_valid && !result_full;
  assign result_push        = item_pop && item.row_end;
  assign result.row_match   = found2;
  assign result.image_match = image_found || found2;
  assign result.last_row    = item.image_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_RUNS; i++) begin
        hist[i] <= SYM_NONE;
      end
      row_found   <= 1'b0;
      image_found <= 1'b0;
    end else if (item_pop) begin
      if (item.row_end) begin
        for (int i = 0; i < MAX_RUNS; i++) begin
          hist[i] <= SYM_NONE;
        end
        row_found   <= 1'b0;
        image_found <= item.image_end ? 1'b0 : (image_found || found2);
      end else begin
        hist      <= h2;
        row_found <= found2;
      end
    end
  end

endmodule

`default_nettype wire

>>> src/scanline_stripe_pattern_detector.sv
// a row-ending pixel's item is registered in the work queue, its result in the result queue
// throughput: one pixel per cycle unless full; results drain at one per cycle
// the front classifies runs, a 4-entry queue feeds the back, a 2-entry queue holds results
// rst (synchronous, active high) restores default levels, clears row and image state,
// and empties both queues
`default_nettype none

module scanline_stripe_pattern_detector
  import ssp_pkg::*;
#(
  parameter int MAX_RUNS = MAX_RUNS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // pixel side
  input  logic       push,
  output logic       full,
  input  logic [7:0] pixel,
  input  logic       row_end,
  input  logic       image_end,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic       row_match,
  output logic       image_match,
  output logic       last_row,
  // configuration writes
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int IW = $bits(item_t);
  localparam int RW = $bits(result_t);

  // configuration registers
  logic [7:0] black_level;
  logic [7:0] gray_level;
  logic [7:0] white_level;
  logic [4:0] required_runs;

  // front to queue
  logic          accept;
  item_t         front_item;
  logic          front_valid;
  logic          queue_full;

  // queue to back
  logic [IW-1:0] queue_rdata;
  logic          queue_empty;
  logic          queue_pop;
  item_t         back_item;

  // back to result queue
  logic          result_full;
  logic          result_push;
  result_t       back_result;
  logic [RW-1:0] result_rdata;
  result_t       out_result;

  // writes are taken at any time
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      black_level   <= BLACK_LEVEL_RST;
      gray_level    <= GRAY_LEVEL_RST;
      white_level   <= WHITE_LEVEL_RST;
      required_runs <= REQUIRED_RUNS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLACK_LEVEL:   black_level   <= cfg_data;
        CFG_GRAY_LEVEL:    gray_level    <= cfg_data;
        CFG_WHITE_LEVEL:   white_level   <= cfg_data;
        CFG_REQUIRED_RUNS: required_runs <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // input stalls only when the work queue is full
  assign full   = queue_full;
  assign accept = push && !full;

  // front: run tracking and level classification
  ssp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel       (pixel),
    .row_end     (row_end),
    .image_end   (image_end),
    .black_level (black_level),
    .gray_level  (gray_level),
    .white_level (white_level),
    .item        (front_item),
    .item_valid  (front_valid)
  );

  // work queue between front and back
  ssp_fifo #(
    .WIDTH (IW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_item),
    .full  (queue_full),
    .pop   (queue_pop),
    .rdata (queue_rdata),
    .empty (queue_empty)
  );

  assign back_item = item_t'(queue_rdata);

  // back: symbol history, window match, row and image flags
  ssp_back #(
    .MAX_RUNS (MAX_RUNS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .required_runs (required_runs),
    .item_valid    (!queue_empty),
    .item          (back_item),
    .item_pop      (queue_pop),
    .result_full   (result_full),
    .result_push   (result_push),
    .result        (back_result)
  );

  // result queue parts the back from the consumer
  ssp_fifo #(
    .WIDTH (RW),
    .DEPTH (RESULT_DEPTH)
  ) u_result (
    .clk   (clk),
    .rst   (rst),
    .push  (result_push),
    .wdata (back_result),
    .full  (result_full),
    .pop   (pop),
    .rdata (result_rdata),
    .empty (empty)
  );

  assign out_result  = result_t'(result_rdata);
  assign row_match   = out_result.row_match;
  assign image_match = out_result.image_match;
  assign last_row    = out_result.last_row;

endmodule

`default_nettype wire

>>> src/ssp_checker.sv
`default_nettype none

module ssp_checker (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input logic row_match,
  input logic image_match,
  input logic last_row,
  input logic cfg_ready
);

  // result queue empty and work queue not full right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // a matching row always marks the image
  a_row_implies_image: assert property (@(posedge clk) disable iff (rst)
    (!empty && row_match) |-> image_match)
    else $error("row match without image match");

  // configuration writes never stall
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port stalled");

  // a waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(row_match) && $stable(image_match)
                          && $stable(last_row)))
    else $error("result changed while stalled");

endmodule

bind scanline_stripe_pattern_detector ssp_checker u_ssp_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .row_match   (row_match),
  .image_match (image_match),
  .last_row    (last_row),
  .cfg_ready   (cfg_ready)
);

`default_nettype wire
